// ----- rtl/core/sfc_pkg.sv -----
package sfc_pkg;

  // Direction codes
  localparam logic ACT_ENC = 1'b0;
  localparam logic ACT_DEC = 1'b1;

  // Small format codes
  localparam logic [1:0] FMT_HALF = 2'd0;
  localparam logic [1:0] FMT_UF11 = 2'd1;
  localparam logic [1:0] FMT_UF10 = 2'd2;
  localparam logic [1:0] FMT_NONE = 2'd3;

  // float32 exponent limits for encoding
  localparam logic [7:0] F32_EXP_SPECIAL = 8'hff;
  localparam logic [7:0] F32_EXP_OVF     = 8'd142;  // 127 + 15
  localparam logic [7:0] F32_EXP_MIN     = 8'd113;  // 127 - 14
  localparam logic [7:0] EXP_REBIAS      = 8'd112;  // 127 - 15

  // Small exponent all ones
  localparam logic [4:0] SMALL_EXP_MAX = 5'h1f;

  // float32 exponent of a small denormal is lead-one position plus this base
  localparam logic [7:0] DEN_BASE_HALF = 8'd103;  // 127 - 24
  localparam logic [7:0] DEN_BASE_UF11 = 8'd107;  // 127 - 20
  localparam logic [7:0] DEN_BASE_UF10 = 8'd108;  // 127 - 19

  // Stage 1: unpacked fields of both views of the word
  typedef struct packed {
    logic        act;
    logic [1:0]  fmt;
    logic        fsgn;   // float32 sign
    logic [7:0]  fexp;   // float32 exponent
    logic [22:0] fman;   // float32 mantissa
    logic        dsgn;   // small sign (half only)
    logic [4:0]  sexp;   // small exponent
    logic [9:0]  sman;   // small mantissa, zero-extended
  } sfc_unp_t;

  // Stage 2: encode done, lead-one found for decode
  typedef struct packed {
    logic        act;
    logic [1:0]  fmt;
    logic        dsgn;
    logic [4:0]  sexp;
    logic [9:0]  sman;
    logic [3:0]  lead;
    logic [15:0] enc;
  } sfc_mid_t;

endpackage

// ----- rtl/core/sfc_unpack.sv -----
module sfc_unpack import sfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic        act,
  input  logic [1:0]  fmt,
  input  logic [31:0] word,
  output logic        out_vld,
  output sfc_unp_t    out_f
);

  sfc_unp_t f_next;

  // Split the word both as float32 and as the chosen small format
  always_comb begin
    f_next.act  = act;
    f_next.fmt  = fmt;
    f_next.fsgn = word[31];
    f_next.fexp = word[30:23];
    f_next.fman = word[22:0];
    case (fmt)
      FMT_HALF: begin
        f_next.dsgn = word[15];
        f_next.sexp = word[14:10];
        f_next.sman = word[9:0];
      end
      FMT_UF11: begin
        f_next.dsgn = 1'b0;
        f_next.sexp = word[10:6];
        f_next.sman = {4'b0, word[5:0]};
      end
      FMT_UF10: begin
        f_next.dsgn = 1'b0;
        f_next.sexp = word[9:5];
        f_next.sman = {5'b0, word[4:0]};
      end
      default: begin
        f_next.dsgn = 1'b0;
        f_next.sexp = '0;
        f_next.sman = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_f <= f_next;
  end

endmodule

// ----- rtl/core/sfc_encode.sv -----
module sfc_encode import sfc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_vld,
  input  sfc_unp_t in_f,
  output logic     out_vld,
  output sfc_mid_t out_m
);

  logic [15:0] enc;
  logic [4:0]  rexp;
  logic [1:0]  cls;   // 0 zero, 1 normal, 2 overflow, 3 special
  logic [3:0]  lead;
  sfc_mid_t    m_next;

  localparam logic [1:0] CLS_ZERO = 2'd0;
  localparam logic [1:0] CLS_NORM = 2'd1;
  localparam logic [1:0] CLS_OVF  = 2'd2;
  localparam logic [1:0] CLS_SPEC = 2'd3;

  // Classify the float32 exponent
  always_comb begin
    rexp = 5'(in_f.fexp - EXP_REBIAS);
    if (in_f.fexp == F32_EXP_SPECIAL) begin
      cls = CLS_SPEC;
    end else if (in_f.fexp > F32_EXP_OVF) begin
      cls = CLS_OVF;
    end else if (in_f.fexp >= F32_EXP_MIN) begin
      cls = CLS_NORM;
    end else begin
      cls = CLS_ZERO;
    end
  end

  // Pack into the small format, truncating the mantissa
  always_comb begin
    enc = '0;
    case (in_f.fmt)
      FMT_HALF: begin
        case (cls)
          CLS_SPEC: enc = {1'b0, SMALL_EXP_MAX, in_f.fman[9:0]};
          CLS_OVF:  enc = {1'b0, SMALL_EXP_MAX, 10'b0};
          CLS_NORM: enc = {1'b0, rexp, in_f.fman[22:13]};
          default:  enc = '0;
        endcase
        enc[15] = in_f.fsgn;
      end
      FMT_UF11: begin
        case (cls)
          CLS_SPEC: enc = {5'b0, SMALL_EXP_MAX, in_f.fman[5:0]};
          CLS_OVF:  enc = {5'b0, SMALL_EXP_MAX, 6'b0};
          CLS_NORM: enc = {5'b0, rexp, in_f.fman[22:17]};
          default:  enc = '0;
        endcase
        if (in_f.fsgn) begin
          enc = '0;
        end
      end
      FMT_UF10: begin
        case (cls)
          CLS_SPEC: enc = {6'b0, SMALL_EXP_MAX, in_f.fman[4:0]};
          CLS_OVF:  enc = {6'b0, SMALL_EXP_MAX, 5'b0};
          CLS_NORM: enc = {6'b0, rexp, in_f.fman[22:18]};
          default:  enc = '0;
        endcase
        if (in_f.fsgn) begin
          enc = '0;
        end
      end
      default: enc = '0;
    endcase
  end

  // Leading-one position of the small mantissa, for denormal decode
  always_comb begin
    lead = '0;
    for (int i = 0; i < 10; i++) begin
      if (in_f.sman[i]) begin
        lead = 4'(i);
      end
    end
  end

  always_comb begin
    m_next.act  = in_f.act;
    m_next.fmt  = in_f.fmt;
    m_next.dsgn = in_f.dsgn;
    m_next.sexp = in_f.sexp;
    m_next.sman = in_f.sman;
    m_next.lead = lead;
    m_next.enc  = enc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_m <= m_next;
  end

endmodule

// ----- rtl/core/sfc_pack.sv -----
module sfc_pack import sfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  sfc_mid_t    in_m,
  output logic        out_vld,
  output logic [31:0] out_word
);

  logic [7:0]  den_base;
  logic [7:0]  den_exp;
  logic [22:0] den_frac;
  logic [22:0] nrm_frac;
  logic [31:0] dec;
  logic [31:0] word_next;

  // Denormal: drop the leading one, shift the rest to the top of the mantissa
  always_comb begin
    case (in_m.fmt)
      FMT_HALF: den_base = DEN_BASE_HALF;
      FMT_UF11: den_base = DEN_BASE_UF11;
      default:  den_base = DEN_BASE_UF10;
    endcase
    den_exp  = den_base + {4'b0, in_m.lead};
    den_frac = ({13'b0, in_m.sman} ^ (23'd1 << in_m.lead)) << (5'd23 - {1'b0, in_m.lead});
  end

  // Normal mantissa alignment
  always_comb begin
    case (in_m.fmt)
      FMT_HALF: nrm_frac = {in_m.sman, 13'b0};
      FMT_UF11: nrm_frac = {in_m.sman[5:0], 17'b0};
      default:  nrm_frac = {in_m.sman[4:0], 18'b0};
    endcase
  end

  // Decode to float32
  always_comb begin
    if (in_m.sexp == '0) begin
      if (in_m.sman == '0) begin
        dec = {in_m.dsgn, 31'b0};
      end else begin
        dec = {in_m.dsgn, den_exp, den_frac};
      end
    end else if (in_m.sexp == SMALL_EXP_MAX) begin
      dec = {in_m.dsgn, F32_EXP_SPECIAL, 13'b0, in_m.sman};
    end else begin
      dec = {in_m.dsgn, 8'(in_m.sexp) + EXP_REBIAS, nrm_frac};
    end
  end

  // Final select; the unused format code gives zero
  always_comb begin
    if (in_m.fmt == FMT_NONE) begin
      word_next = '0;
    end else if (in_m.act == ACT_ENC) begin
      word_next = {16'b0, in_m.enc};
    end else begin
      word_next = dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

// ----- rtl/core/small_float_format_converter_top.sv -----
// Channel  | Handshake         | Data ports
// ---------+-------------------+----------------------
// command  | start, busy       | action, format, value
// result   | done (strobe)     | result
//
// One beat enters per cycle; busy stays low.
// Pipeline stages: unpack, encode and lead-one detect, decode and select.
// rst clears the valid bits of all three stages; data registers are not reset.
// The receiver cannot stall: done is high for one cycle per command beat.
module small_float_format_converter_top import sfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [1:0]  format,
  input  logic [31:0] value,
  output logic        done,
  output logic [31:0] result
);

  logic     acc;
  logic     v1;
  logic     v2;
  sfc_unp_t s1;
  sfc_mid_t s2;

  // The pipeline never holds off a beat
  assign busy = 1'b0;
  assign acc  = start & ~busy;

  sfc_unpack u_unpack (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (acc),
    .act     (action),
    .fmt     (format),
    .word    (value),
    .out_vld (v1),
    .out_f   (s1)
  );

  sfc_encode u_encode (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (v1),
    .in_f    (s1),
    .out_vld (v2),
    .out_m   (s2)
  );

  sfc_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (v2),
    .in_m     (s2),
    .out_vld  (done),
    .out_word (result)
  );

endmodule
